[src/rfpvm_pkg.sv]
// Package for the RF bridge power and VSWR meter: payload words, constants
// and the detector line-voltage table. No dependencies.
`timescale 1ns / 1ps
package rfpvm_pkg;

  localparam int PEAK_DEPTH_DEF = 32;
  localparam int AVG_DEPTH_DEF  = 32;

  localparam int ROM_N = 1024;
  localparam int ROM_W = 28;  // line voltage, units of 2^-16 V
  localparam int DIV_W = 32;  // divider dividend and quotient
  localparam int DVS_W = 28;  // divider divisor

  localparam logic [15:0] POWER_CLIP = 16'd60000;
  localparam logic [23:0] CLIP_HI    = 24'd300000;  // 5 * POWER_CLIP
  localparam logic [18:0] RECIP5     = 19'd419431;  // ceil(2^21 / 5)
  localparam int          RECIP_SH   = 21;
  localparam logic [13:0] VSWR_HIGH  = 14'd9999;
  localparam logic [13:0] VSWR_LOW   = 14'd10;
  localparam logic [27:0] V_MIN      = 28'd6553;    // below 0.1 V
  localparam logic [21:0] DBM_OFS    = 22'd960000;
  localparam logic [22:0] DBM_RECIP  = 23'd4294968; // ceil(2^32 / 1000)
  localparam int          DBM_SH     = 32;

  typedef struct packed {
    logic       command;
    logic [9:0] adc_reading;
  } in_t;

  typedef struct packed {
    logic signed [11:0] fwd_tenth_dbm;
    logic signed [11:0] rev_tenth_dbm;
    logic [15:0]        fwd_avg_power;
    logic [15:0]        fwd_peak_power;
    logic [15:0]        rev_avg_power;
    logic [15:0]        rev_peak_power;
    logic [13:0]        vswr_tenths;
    logic [15:0]        fwd_window_peak;
    logic [15:0]        rev_window_peak;
    logic [15:0]        fwd_window_avg;
    logic [15:0]        rev_window_avg;
  } out_t;

  typedef logic [ROM_W-1:0] rom_arr_t [ROM_N];

  // line voltage in units of 1e-5 V
  localparam logic [28:0] LINE_E5 [ROM_N] = '{
112,114,115,117,119,120,122,124,126,128,129,131,133,135,137,139,
141,143,145,147,150,152,154,156,158,161,163,165,168,170,173,175,
178,180,183,186,188,191,194,197,200,202,205,208,211,214,218,221,
224,227,231,234,237,241,244,248,251,255,259,262,266,270,274,278,
282,286,290,295,299,303,308,312,317,321,326,331,335,340,345,350,
355,361,366,371,376,382,388,393,399,405,411,416,423,429,435,441,
448,454,461,467,474,481,488,495,502,510,517,525,532,540,548,556,
564,572,580,589,597,606,615,624,633,642,651,661,670,680,690,700,
710,721,731,742,752,763,774,786,797,809,820,832,844,857,869,882,
895,908,921,934,948,962,976,990,1004,1019,1033,1048,1064,1079,1095,1111,
1127,1143,1160,1177,1194,1211,1229,1247,1265,1283,1302,1321,1340,1359,1379,1399,
1419,1440,1461,1482,1504,1526,1548,1570,1593,1616,1640,1664,1688,1712,1737,1762,
1788,1814,1840,1867,1894,1922,1950,1978,2007,2036,2065,2095,2126,2157,2188,2220,
2252,2285,2318,2352,2386,2421,2456,2491,2528,2564,2602,2639,2678,2717,2756,2796,
2837,2878,2920,2962,3005,3049,3093,3138,3184,3230,3277,3325,3373,3422,3472,3522,
3573,3625,3678,3731,3786,3841,3897,3953,4011,4069,4128,4188,4249,4311,4373,4437,
4501,4567,4633,4700,4769,4838,4908,4979,5052,5125,5200,5275,5352,5430,5509,5589,
5670,5752,5836,5921,6007,6094,6182,6272,6363,6456,6550,6645,6741,6839,6939,7039,
7142,7246,7351,7458,7566,7676,7787,7901,8015,8132,8250,8370,8492,8615,8740,8867,
8996,9127,9259,9394,9530,9669,9809,9952,10096,10243,10392,10543,10696,10852,11009,11169,
11331,11496,11663,11833,12005,12179,12356,12535,12718,12902,13090,13280,13473,13669,13867,14069,
14273,14481,14691,14905,15121,15341,15564,15790,16019,16252,16488,16728,16971,17217,17468,17721,
17979,18240,18505,18774,19047,19324,19604,19889,20178,20472,20769,21071,21377,21688,22003,22322,
22647,22976,23310,23648,23992,24341,24694,25053,25417,25786,26161,26541,26927,27318,27715,28118,
28526,28941,29361,29788,30221,30660,31105,31557,32016,32481,32953,33432,33918,34410,34910,35418,
35932,36454,36984,37521,38067,38620,39181,39750,40328,40914,41508,42111,42723,43344,43974,44613,
45261,45919,46586,47263,47950,48646,49353,50070,50798,51536,52285,53044,53815,54597,55390,56195,
57012,57840,58681,59533,60398,61276,62166,63070,63986,64916,65859,66816,67787,68772,69771,70785,
71813,72857,73915,74989,76079,77184,78306,79444,80598,81769,82957,84163,85386,86626,87885,89162,
90458,91772,93105,94458,95831,97223,98636,100069,101523,102998,104495,106013,107554,109116,110702,
112310,
113942,115598,117278,118982,120710,122464,124244,126049,127881,129739,131624,133537,135477,137445,
139442,141469,
143524,145610,147725,149872,152050,154259,156500,158774,161081,163422,165796,168205,170649,173129,
175645,178197,
180786,183413,186078,188782,191525,194308,197131,199995,202901,205850,208841,211875,214954,218077,
221246,224461,
227722,231031,234388,237794,241249,244754,248310,251918,255579,259293,263060,266882,270760,274695,
278686,282735,
286843,291011,295240,299530,303882,308297,312777,317322,321933,326610,331356,336171,341055,346011,
351039,356139,
361314,366564,371890,377294,382776,388338,393981,399705,405513,411405,417383,423448,429601,435843,
442176,448601,
455119,461732,468441,475248,482153,489159,496267,503477,510793,518215,525745,533384,541134,548997,
556974,565067,
573278,581608,590058,598632,607330,616155,625108,634191,643406,652755,662239,671862,681624,691528,
701576,711771,
722113,732605,743250,754050,765006,776122,787399,798840,810448,822224,834171,846292,858588,871064,
883721,896561,
909589,922805,936214,949817,963618,977620,991825,1006236,1020857,1035691,1050739,1066007,1081496,
1097211,1113153,1129328,
1145737,1162385,1179275,1196410,1213794,1231431,1249324,1267477,1285894,1304578,1323534,1342765,
1362276,1382070,1402152,1422525,
1443195,1464165,1485440,1507023,1528921,1551136,1573675,1596541,1619739,1643274,1667151,1691375,
1715951,1740885,1766180,1791843,
1817879,1844293,1871091,1898279,1925861,1953845,1982234,2011037,2040258,2069903,2099979,2130492,
2161449,2192855,2224718,2257044,
2289839,2323111,2356867,2391112,2425856,2461104,2496865,2533145,2569952,2607294,2645179,2683614,
2722607,2762167,2802302,2843021,
2884330,2926240,2968759,3011896,3055660,3100059,3145104,3190803,3237166,3284203,3331923,3380337,
3429454,3479285,3529840,3581129,
3633164,3685955,3739513,3793849,3848974,3904901,3961640,4019204,4077604,4136852,4196962,4257945,
4319814,4382582,4446262,4510867,
4576411,4642907,4710370,4778813,4848250,4918696,4990166,5062674,5136236,5210867,5286582,5363398,
5441329,5520393,5600606,5681984,
5764545,5848305,5933282,6019494,6106959,6195695,6285720,6377053,6469713,6563719,6659092,6755850,
6854014,6953605,7054642,7157148,
7261143,7366649,7473689,7582283,7692456,7804229,7917626,8032671,8149388,8267801,8387934,8509813,
8633462,8758909,8886178,9015296,
9146291,9279189,9414018,9550806,9689581,9830373,9973211,10118124,10265143,10414298,10565620,
10719141,10874893,11032908,11193219,11355859,
11520863,11688264,11858097,12030398,12205203,12382547,12562469,12745005,12930193,13118072,
13308681,13502059,13698247,13897286,14099217,14304082,
14511924,14722786,14936712,15153746,15373934,15597321,15823954,16053880,16287146,16523803,
16763898,17007481,17254604,17505318,17759675,18017727,
18279529,18545135,18814601,19087981,19365334,19646718,19932189,20221809,20515637,20813734,
21116163,21422986,21734267,22050072,22370465,22695513,
23025284,23359847,23699272,24043628,24392988,24747424,25107010,25471821,25841933,26217423,
26598369,26984850,27376946,27774740,28178314,28587752,
29003139,29424562,29852108,30285866,30725928,31172383,31625325,32084849,32551050,33024025,
33503872,33990692,34484585,34985654,35494005,36009741,
36532972,37063805,37602351,38148723,38703033,39265398,39835934,40414760,41001996,41597765,
42202191,42815400,43437518,44068676,44709005,45358638,
46017710,46686359,47364723,48052944,48751165,49459532,50178191,50907293,51646988,52397432,
53158780,53931190,54714823,55509843,56316415,57134707,
57964888,58807132,59661615,60528513,61408007,62300281,63205519,64123911,65055647,66000922,
66959932,67932876,68919958,69921382,70937357,71968094,
73013808,74074717,75151041,76243005,77350834,78474761,79615019,80771845,81945480,83136168,
84344157,85569699,86813048,88074463,89354206,90652545,
91969749,93306092,94661853,96037313,97432759,98848482,100284774,101741937,103220273,104720089,
106241698,107785416,109351565,110940470,112552463,114187878,
115847056,117530343,119238088,120970647,122728380,124511654,126320839,128156312,130018455,
131907656,133824307,135768807,137741562,139742981,141773481,143833485,
145923421,148043724,150194836,152377205,154591283,156837533,159116421,161428422,163774017,
166153694,168567949,171017283,173502206,176023237,178580898,181175723,
183808251,186479030,189188617,191937574,194726475,197555899,200426435,203338681,206293243,
209290735,212331781,215417014,218547077,221722620,224944305,228212801,
231528790,234892961,238306014,241768659,245281618,248845621,252461409,256129736,259851365,
263627070,267457636,271343862,275286556,279286538,283344640,287461708
  };

  // Convert the table to 2^-16 V, rounding halves up; evaluated at elaboration.
  function automatic rom_arr_t build_rom();
    rom_arr_t r;
    for (int i = 0; i < ROM_N; i++) begin
      r[i] = ROM_W'((64'(LINE_E5[i]) * 64'd65536 + 64'd50000) / 64'd100000);
    end
    return r;
  endfunction

endpackage

[src/rf_bridge_power_vswr_meter_unit.sv]
// RF bridge power and VSWR meter top level: accumulators, tick sequencer,
// shared divider, voltage ROM and ring memories. Depends on rfpvm_pkg.
//
// A detector sample is accepted in the idle state; samples may follow back to back.
// A tick holds the input through the averaging divisions, the ROM and power steps,
// the dBm steps, the ratio division and the ring scan, and longer while an earlier
// result still waits in the output register.
// Reset clears control state and ring valid bits at once.
`timescale 1ns / 1ps
module rf_bridge_power_vswr_meter_unit
  import rfpvm_pkg::*;
#(
  parameter int PEAK_DEPTH = PEAK_DEPTH_DEF,
  parameter int AVG_DEPTH  = AVG_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o,
  input  logic       cfg_we_i,
  input  logic [9:0] cfg_wdata_i
);

  localparam int PA_W    = $clog2(PEAK_DEPTH);
  localparam int AA_W    = $clog2(AVG_DEPTH);
  localparam int SCAN_N  = (PEAK_DEPTH > AVG_DEPTH) ? PEAK_DEPTH : AVG_DEPTH;
  localparam int SC_W    = $clog2(SCAN_N + 1);
  localparam int SUM_W   = 16 + $clog2(AVG_DEPTH);
  localparam int DC_W    = $clog2(DIV_W);
  localparam int MEAN_SH = SUM_W + $clog2(AVG_DEPTH);
  localparam int MP_W    = 2 * SUM_W + 1;
  localparam logic [MP_W-1:0] MEAN_RECIP =
    MP_W'(((64'd1 << MEAN_SH) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));
  localparam rom_arr_t ROM_V = build_rom();

  typedef enum logic [3:0] {
    ST_IDLE, ST_AVG, ST_DIV, ST_ROM, ST_SQ, ST_PW, ST_PW2,
    ST_DBM, ST_DBQ, ST_DBW, ST_VSWR, ST_WR, ST_SCAN, ST_MEAN, ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    J_FA, J_RA, J_VSWR
  } job_e;

  state_e state_q;
  job_e   job_q;
  logic   sel_q;
  logic [1:0] k_q;

  logic [9:0]  loss_q;
  logic        next_rev_q;
  logic [9:0]  fpk_q, rpk_q;
  logic [17:0] fsum_q, rsum_q;
  logic [7:0]  fcnt_q, rcnt_q;

  logic [DIV_W-1:0] dvd_q;
  logic [DVS_W-1:0] dvs_q, rem_q;
  logic [DC_W-1:0]  dcnt_q;
  logic             neg_q;

  logic [9:0]       fa_q, ra_q;
  logic [ROM_W-1:0] rom_q, fv_q, rv_q;
  logic [55:0]      sq_q;
  logic [37:0]      prod_q;
  logic             clip_q;
  logic [15:0]      pwr_q [4];
  logic [21:0]      mmag_q;
  logic [44:0]      dbq_q;
  logic [11:0]      fdb_q, rdb_q;
  logic [13:0]      vswr_q;
  logic [15:0]      fmean_q, rmean_q;

  logic [PA_W-1:0]  pslot_q, pslot_nx;
  logic [AA_W-1:0]  aslot_q, aslot_nx;
  logic             pk_vld_q [PEAK_DEPTH];
  logic             av_vld_q [AVG_DEPTH];
  logic [31:0]      pk_mem [PEAK_DEPTH];
  logic [31:0]      av_mem [AVG_DEPTH];
  logic [31:0]      pk_rd_q, av_rd_q;
  logic             pk_ok_q, av_ok_q;
  logic [SC_W-1:0]  scan_q;
  logic [PA_W-1:0]  pk_raddr;
  logic [AA_W-1:0]  av_raddr;
  logic [15:0]      fmax_q, rmax_q;
  logic [SUM_W-1:0] fasum_q, rasum_q;
  logic [MP_W-1:0]  fm_prod, rm_prod;

  logic             out_valid_q;
  out_t             out_q;

  // divider step
  logic [DVS_W:0]   rem_sh;
  logic             qbit;
  logic [DVS_W-1:0] rem_nx;
  logic [DIV_W-1:0] quo;

  always_comb begin
    rem_sh = {rem_q, dvd_q[DIV_W-1]};
    qbit   = (rem_sh >= {1'b0, dvs_q});
    rem_nx = qbit ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];
    quo    = {dvd_q[DIV_W-2:0], qbit};
  end

  // ROM address by power phase
  logic [9:0] rom_addr;
  always_comb begin
    case (k_q)
      2'd0:    rom_addr = fpk_q;
      2'd1:    rom_addr = rpk_q;
      2'd2:    rom_addr = fa_q;
      default: rom_addr = ra_q;
    endcase
  end

  // dBm magnitude and sign
  logic [9:0]  dbm_a;
  logic [21:0] mpos, mmag;
  logic        mneg;
  always_comb begin
    dbm_a = sel_q ? ra_q : fa_q;
    mpos  = 22'(dbm_a * 11'd1253) + 22'(loss_q * 10'd1000);
    mneg  = (mpos < DBM_OFS);
    mmag  = mneg ? (DBM_OFS - mpos) : (mpos - DBM_OFS);
  end

  logic [23:0] sq_hi;
  assign sq_hi = sq_q[55:32];

  // ring means by reciprocal multiplication, exact over the whole sum range
  assign fm_prod = MP_W'(fasum_q) * MEAN_RECIP;
  assign rm_prod = MP_W'(rasum_q) * MEAN_RECIP;

  assign pslot_nx = (pslot_q == PA_W'(PEAK_DEPTH - 1)) ? '0 : pslot_q + 1'b1;
  assign aslot_nx = (aslot_q == AA_W'(AVG_DEPTH - 1)) ? '0 : aslot_q + 1'b1;
  assign pk_raddr = scan_q[PA_W-1:0];
  assign av_raddr = scan_q[AA_W-1:0];

  always_ff @(posedge clk_i) begin
    rom_q <= ROM_V[rom_addr];
  end

  // ring memories: write the new tick word, read one entry a cycle while scanning
  always_ff @(posedge clk_i) begin
    if (state_q == ST_WR) begin
      pk_mem[pslot_nx] <= {pwr_q[0], pwr_q[1]};
      av_mem[aslot_nx] <= {pwr_q[2], pwr_q[3]};
    end
    pk_rd_q <= pk_mem[pk_raddr];
    av_rd_q <= av_mem[av_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_q       <= J_FA;
      sel_q       <= 1'b0;
      k_q         <= '0;
      loss_q      <= 10'd500;
      next_rev_q  <= 1'b0;
      fpk_q       <= '0;
      rpk_q       <= '0;
      fsum_q      <= '0;
      rsum_q      <= '0;
      fcnt_q      <= '0;
      rcnt_q      <= '0;
      dcnt_q      <= '0;
      pslot_q     <= '0;
      aslot_q     <= '0;
      scan_q      <= '0;
      pk_ok_q     <= 1'b0;
      av_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < PEAK_DEPTH; i++) pk_vld_q[i] <= 1'b0;
      for (int i = 0; i < AVG_DEPTH; i++)  av_vld_q[i] <= 1'b0;
    end else begin
      if (cfg_we_i) loss_q <= cfg_wdata_i;
      if (out_valid_q && !out_stall_i && state_q != ST_OUT) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (!in_data_i.command) begin
              if (next_rev_q) begin
                if (in_data_i.adc_reading > rpk_q) rpk_q <= in_data_i.adc_reading;
                rsum_q <= rsum_q + 18'(in_data_i.adc_reading);
                rcnt_q <= rcnt_q + 1'b1;
              end else begin
                if (in_data_i.adc_reading > fpk_q) fpk_q <= in_data_i.adc_reading;
                fsum_q <= fsum_q + 18'(in_data_i.adc_reading);
                fcnt_q <= fcnt_q + 1'b1;
              end
              next_rev_q <= !next_rev_q;
            end else begin
              sel_q   <= 1'b0;
              state_q <= ST_AVG;
            end
          end
        end

        ST_AVG: begin
          if ((sel_q ? rcnt_q : fcnt_q) == '0) begin
            // no samples: average is zero
            if (!sel_q) begin
              fa_q  <= '0;
              sel_q <= 1'b1;
            end else begin
              ra_q    <= '0;
              k_q     <= '0;
              state_q <= ST_ROM;
            end
          end else begin
            dvd_q   <= DIV_W'(sel_q ? rsum_q : fsum_q);
            dvs_q   <= DVS_W'(sel_q ? rcnt_q : fcnt_q);
            job_q   <= sel_q ? J_RA : J_FA;
            rem_q   <= '0;
            dcnt_q  <= '0;
            state_q <= ST_DIV;
          end
        end

        ST_DIV: begin
          dvd_q  <= quo;
          rem_q  <= rem_nx;
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == DC_W'(DIV_W - 1)) begin
            case (job_q)
              J_FA: begin
                fa_q    <= (quo > DIV_W'(1023)) ? 10'd1023 : quo[9:0];
                sel_q   <= 1'b1;
                state_q <= ST_AVG;
              end
              J_RA: begin
                ra_q    <= (quo > DIV_W'(1023)) ? 10'd1023 : quo[9:0];
                k_q     <= '0;
                state_q <= ST_ROM;
              end
              default: begin
                vswr_q  <= (quo > DIV_W'(VSWR_HIGH)) ? VSWR_HIGH : quo[13:0];
                state_q <= ST_WR;
              end
            endcase
          end
        end

        ST_ROM: state_q <= ST_SQ;

        ST_SQ: begin
          sq_q <= 56'(rom_q) * 56'(rom_q);
          if (k_q == 2'd0) fv_q <= rom_q;
          if (k_q == 2'd1) rv_q <= rom_q;
          state_q <= ST_PW;
        end

        ST_PW: begin
          // divide by five by reciprocal; clip in parallel, product exact below it
          clip_q  <= (sq_hi >= CLIP_HI);
          prod_q  <= 38'(sq_hi[18:0]) * 38'(RECIP5);
          state_q <= ST_PW2;
        end

        ST_PW2: begin
          pwr_q[k_q] <= clip_q ? POWER_CLIP : prod_q[RECIP_SH+15:RECIP_SH];
          if (k_q == 2'd3) begin
            sel_q   <= 1'b0;
            state_q <= ST_DBM;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= ST_ROM;
          end
        end

        ST_DBM: begin
          mmag_q  <= mmag;
          neg_q   <= mneg;
          state_q <= ST_DBQ;
        end

        // divide the magnitude by 1000 by reciprocal multiplication
        ST_DBQ: begin
          dbq_q   <= 45'(mmag_q) * 45'(DBM_RECIP);
          state_q <= ST_DBW;
        end

        ST_DBW: begin
          if (!sel_q) begin
            fdb_q   <= neg_q ? -dbq_q[DBM_SH+11:DBM_SH] : dbq_q[DBM_SH+11:DBM_SH];
            sel_q   <= 1'b1;
            state_q <= ST_DBM;
          end else begin
            rdb_q   <= neg_q ? -dbq_q[DBM_SH+11:DBM_SH] : dbq_q[DBM_SH+11:DBM_SH];
            state_q <= ST_VSWR;
          end
        end

        ST_VSWR: begin
          if (fv_q <= V_MIN) begin
            vswr_q  <= VSWR_LOW;
            state_q <= ST_WR;
          end else if (fv_q == rv_q) begin
            vswr_q  <= VSWR_HIGH;
            state_q <= ST_WR;
          end else begin
            dvd_q   <= DIV_W'((33'(fv_q) + 33'(rv_q)) * 33'd10);
            dvs_q   <= (fv_q > rv_q) ? (fv_q - rv_q) : (rv_q - fv_q);
            job_q   <= J_VSWR;
            rem_q   <= '0;
            dcnt_q  <= '0;
            state_q <= ST_DIV;
          end
        end

        ST_WR: begin
          pslot_q            <= pslot_nx;
          aslot_q            <= aslot_nx;
          pk_vld_q[pslot_nx] <= 1'b1;
          av_vld_q[aslot_nx] <= 1'b1;
          fmax_q  <= '0;
          rmax_q  <= '0;
          fasum_q <= '0;
          rasum_q <= '0;
          scan_q  <= '0;
          pk_ok_q <= 1'b0;
          av_ok_q <= 1'b0;
          state_q <= ST_SCAN;
        end

        ST_SCAN: begin
          // data of the previous cycle's read is folded in here
          pk_ok_q <= (scan_q < SC_W'(PEAK_DEPTH)) && pk_vld_q[pk_raddr];
          av_ok_q <= (scan_q < SC_W'(AVG_DEPTH)) && av_vld_q[av_raddr];
          if (pk_ok_q) begin
            if (pk_rd_q[31:16] > fmax_q) fmax_q <= pk_rd_q[31:16];
            if (pk_rd_q[15:0] > rmax_q)  rmax_q <= pk_rd_q[15:0];
          end
          if (av_ok_q) begin
            fasum_q <= fasum_q + SUM_W'(av_rd_q[31:16]);
            rasum_q <= rasum_q + SUM_W'(av_rd_q[15:0]);
          end
          scan_q <= scan_q + 1'b1;
          if (scan_q == SC_W'(SCAN_N)) begin
            state_q <= ST_MEAN;
          end
        end

        ST_MEAN: begin
          fmean_q <= fm_prod[MEAN_SH+15:MEAN_SH];
          rmean_q <= rm_prod[MEAN_SH+15:MEAN_SH];
          state_q <= ST_OUT;
        end

        ST_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.fwd_tenth_dbm   <= fdb_q;
            out_q.rev_tenth_dbm   <= rdb_q;
            out_q.fwd_avg_power   <= pwr_q[2];
            out_q.fwd_peak_power  <= pwr_q[0];
            out_q.rev_avg_power   <= pwr_q[3];
            out_q.rev_peak_power  <= pwr_q[1];
            out_q.vswr_tenths     <= vswr_q;
            out_q.fwd_window_peak <= fmax_q;
            out_q.rev_window_peak <= rmax_q;
            out_q.fwd_window_avg  <= fmean_q;
            out_q.rev_window_avg  <= rmean_q;
            out_valid_q <= 1'b1;
            // drop the accumulators for the next interval
            fpk_q   <= '0;
            rpk_q   <= '0;
            fsum_q  <= '0;
            rsum_q  <= '0;
            fcnt_q  <= '0;
            rcnt_q  <= '0;
            state_q <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result word raised outside the output step");

  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dcnt_q != '0) |-> (state_q == ST_DIV))
    else $error("divider count running outside a division");

  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && !(out_valid_q && out_stall_i))
      |=> (fcnt_q == '0 && rcnt_q == '0 && fsum_q == '0 && state_q == ST_IDLE))
    else $error("accumulators not cleared after a tick");

endmodule

[tb/sv/rf_bridge_power_vswr_meter_unit_test.sv]
// Self-checking testbench for rf_bridge_power_vswr_meter_unit: drives detector
// samples and ticks, predicts each tick result and compares it field by field.
// Depends on rfpvm_pkg and the unit under test only.
`timescale 1ns / 1ps
module rf_bridge_power_vswr_meter_unit_test;
  import rfpvm_pkg::*;

  localparam int RING_DEPTH = 32;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  in_t        in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_t       out_data_o;
  logic       cfg_we_i = 1'b0;
  logic [9:0] cfg_wdata_i = '0;

  rf_bridge_power_vswr_meter_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // meter model state
  logic [9:0]  loss_tenth_db;
  logic        to_reverse;
  logic [9:0]  fwd_peak, rev_peak;
  logic [17:0] fwd_sum, rev_sum;
  logic [7:0]  fwd_cnt, rev_cnt;
  logic [15:0] fwd_peak_ring [RING_DEPTH];
  logic [15:0] rev_peak_ring [RING_DEPTH];
  logic [15:0] fwd_avg_ring [RING_DEPTH];
  logic [15:0] rev_avg_ring [RING_DEPTH];
  int          ring_pos;

  out_t pending_readings[$];
  int   n_errors = 0;
  int   n_samples = 0;
  int   n_ticks = 0;
  int   n_checked = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;

  function automatic logic [27:0] volts_of(input logic [9:0] idx);
    return 28'((64'(LINE_E5[idx]) * 64'd65536 + 64'd50000) / 64'd100000);
  endfunction

  function automatic logic [15:0] watts_of(input logic [27:0] v);
    longint unsigned p;
    p = (64'(v) * 64'(v)) / (64'd5 << 32);
    return (p > 60000) ? 16'd60000 : 16'(p);
  endfunction

  function automatic logic [9:0] mean_reading(input logic [17:0] s, input logic [7:0] c);
    int unsigned a;
    if (c == 0) return 10'd0;
    a = s / c;
    return (a > 1023) ? 10'd1023 : 10'(a);
  endfunction

  function automatic logic signed [11:0] dbm_of(input logic [9:0] avg);
    longint m;
    m = -960000 + 1253 * longint'(avg) + 1000 * longint'(loss_tenth_db);
    return 12'(m / 1000);
  endfunction

  task automatic meter_reset();
    loss_tenth_db = 10'd500;
    to_reverse = 1'b0;
    fwd_peak = '0; rev_peak = '0;
    fwd_sum = '0; rev_sum = '0;
    fwd_cnt = '0; rev_cnt = '0;
    ring_pos = 0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      fwd_peak_ring[i] = '0; rev_peak_ring[i] = '0;
      fwd_avg_ring[i] = '0; rev_avg_ring[i] = '0;
    end
  endtask

  task automatic meter_step(input in_t w);
    out_t r;
    logic [9:0] fa, ra;
    logic [27:0] fv, rv;
    longint unsigned q, den;
    int unsigned fsum, rsum;
    if (!w.command) begin
      n_samples++;
      if (to_reverse) begin
        if (w.adc_reading > rev_peak) rev_peak = w.adc_reading;
        rev_sum = rev_sum + 18'(w.adc_reading);
        rev_cnt = rev_cnt + 8'd1;
      end else begin
        if (w.adc_reading > fwd_peak) fwd_peak = w.adc_reading;
        fwd_sum = fwd_sum + 18'(w.adc_reading);
        fwd_cnt = fwd_cnt + 8'd1;
      end
      to_reverse = !to_reverse;
      return;
    end
    n_ticks++;
    ring_pos = (ring_pos + 1 >= RING_DEPTH) ? 0 : ring_pos + 1;
    fa = mean_reading(fwd_sum, fwd_cnt);
    ra = mean_reading(rev_sum, rev_cnt);
    fv = volts_of(fwd_peak);
    rv = volts_of(rev_peak);
    r.fwd_tenth_dbm  = dbm_of(fa);
    r.rev_tenth_dbm  = dbm_of(ra);
    r.fwd_avg_power  = watts_of(volts_of(fa));
    r.fwd_peak_power = watts_of(fv);
    r.rev_avg_power  = watts_of(volts_of(ra));
    r.rev_peak_power = watts_of(rv);
    fwd_avg_ring[ring_pos]  = r.fwd_avg_power;
    rev_avg_ring[ring_pos]  = r.rev_avg_power;
    fwd_peak_ring[ring_pos] = r.fwd_peak_power;
    rev_peak_ring[ring_pos] = r.rev_peak_power;
    if (64'(fv) * 10 < 65536) begin
      r.vswr_tenths = 14'd10;
    end else if (fv == rv) begin
      r.vswr_tenths = 14'd9999;
    end else begin
      den = (fv > rv) ? 64'(fv - rv) : 64'(rv - fv);
      q = (64'd10 * (64'(fv) + 64'(rv))) / den;
      r.vswr_tenths = (q > 9999) ? 14'd9999 : 14'(q);
    end
    r.fwd_window_peak = '0; r.rev_window_peak = '0;
    fsum = 0; rsum = 0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      if (fwd_peak_ring[i] > r.fwd_window_peak) r.fwd_window_peak = fwd_peak_ring[i];
      if (rev_peak_ring[i] > r.rev_window_peak) r.rev_window_peak = rev_peak_ring[i];
      fsum += fwd_avg_ring[i];
      rsum += rev_avg_ring[i];
    end
    r.fwd_window_avg = 16'(fsum / RING_DEPTH);
    r.rev_window_avg = 16'(rsum / RING_DEPTH);
    pending_readings.push_back(r);
    fwd_peak = '0; rev_peak = '0;
    fwd_sum = '0; rev_sum = '0;
    fwd_cnt = '0; rev_cnt = '0;
  endtask

  // hold the word until accepted; valid stays high for a back-to-back word
  task automatic send_word(input logic cmd, input logic [9:0] adc);
    in_t w;
    w.command = cmd;
    w.adc_reading = adc;
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    meter_step(w);
  endtask

  task automatic send_tick();
    send_word(1'b1, '0);
  endtask

  // drain the results, let a tick in flight finish, then write the coupler loss
  task automatic set_loss(input logic [9:0] val);
    in_valid_i <= 1'b0;
    wait (pending_readings.size() == 0);
    repeat (400) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    loss_tenth_db = val;
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: mismatch in %s: expected %0d, got %0d", $time, name, exp_v, act_v);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_data_o);
        n_errors++;
      end else begin
        e = pending_readings.pop_front();
        n_checked++;
        check_field("fwd_tenth_dbm", e.fwd_tenth_dbm, out_data_o.fwd_tenth_dbm);
        check_field("rev_tenth_dbm", e.rev_tenth_dbm, out_data_o.rev_tenth_dbm);
        check_field("fwd_avg_power", e.fwd_avg_power, out_data_o.fwd_avg_power);
        check_field("fwd_peak_power", e.fwd_peak_power, out_data_o.fwd_peak_power);
        check_field("rev_avg_power", e.rev_avg_power, out_data_o.rev_avg_power);
        check_field("rev_peak_power", e.rev_peak_power, out_data_o.rev_peak_power);
        check_field("vswr_tenths", e.vswr_tenths, out_data_o.vswr_tenths);
        check_field("fwd_window_peak", e.fwd_window_peak, out_data_o.fwd_window_peak);
        check_field("rev_window_peak", e.rev_window_peak, out_data_o.rev_window_peak);
        check_field("fwd_window_avg", e.fwd_window_avg, out_data_o.fwd_window_avg);
        check_field("rev_window_avg", e.rev_window_avg, out_data_o.rev_window_avg);
      end
    end
  end

  task automatic test_directed();
    send_tick();                                   // no samples on either channel
    send_word(1'b0, 10'd1023); send_word(1'b0, 10'd0);
    send_tick();                                   // full fwd, zero reverse in odd runs
    send_word(1'b0, 10'd0); send_word(1'b0, 10'd1023);
    send_tick();                                   // forward below 0.1 V in odd runs
    send_word(1'b0, 10'd700); send_word(1'b0, 10'd700);
    send_tick();                                   // equal peaks
    send_word(1'b0, 10'd1023); send_word(1'b0, 10'd1023);
    send_word(1'b0, 10'd512); send_word(1'b0, 10'd341);
    send_tick();
    send_word(1'b0, 10'd900);
    send_tick();                                   // odd count: next word switches side
    send_word(1'b0, 10'd600);
    send_word(1'b0, 10'd650);
    send_tick();
    send_tick();
  endtask

  // wrap the count to zero, then one more word per channel pushes the mean past full scale
  task automatic test_accumulator_wrap();
    for (int i = 0; i < 512; i++) send_word(1'b0, 10'd1000);
    send_tick();
    for (int i = 0; i < 512; i++) send_word(1'b0, 10'd1000);
    send_word(1'b0, 10'd1023); send_word(1'b0, 10'd1023);
    send_tick();
  endtask

  function automatic logic [9:0] pick_reading();
    case ($urandom_range(9))
      0:       return 10'd0;
      1:       return 10'd1023;
      2:       return 10'($urandom_range(1023, 900));
      default: return 10'($urandom_range(1023));
    endcase
  endfunction

  task automatic test_random_mix(input int n_words);
    int sent;
    int burst;
    sent = 0;
    while (sent < n_words) begin
      case ($urandom_range(19))
        0:       burst = $urandom_range(60, 30);
        1:       burst = 0;
        default: burst = $urandom_range(24);
      endcase
      for (int i = 0; i < burst; i++) send_word(1'b0, pick_reading());
      send_tick();
      sent += burst + 1;
    end
  endtask

  initial begin
    meter_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    set_loss(10'd0);
    test_directed();
    set_loss(10'd1023);
    test_directed();
    set_loss(10'd1000);
    test_accumulator_wrap();

    set_loss(10'($urandom_range(1000)));
    idle_pct = 0;  stall_pct = 0;
    test_random_mix(125);
    set_loss(10'd0);
    idle_pct = 58; stall_pct = 0;
    test_random_mix(125);
    set_loss(10'd1000);
    idle_pct = 0;  stall_pct = 58;
    test_random_mix(125);
    set_loss(10'd500);
    idle_pct = 35; stall_pct = 35;
    test_random_mix(125);

    in_valid_i <= 1'b0;
    wait (pending_readings.size() == 0);
    repeat (400) @(posedge clk_i);
    $display("Covered %0d detector samples and %0d ticks; %0d results compared.",
             n_samples, n_ticks, n_checked);
    $display("Coupler loss swept over 0, 500, 1000 and 1023, with sender and receiver gaps.");
    if (n_errors == 0 && pending_readings.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out with %0d results outstanding.", pending_readings.size());
    $display("FAIL");
    $finish;
  end

endmodule

[sim.f]
src/rfpvm_pkg.sv
src/rf_bridge_power_vswr_meter_unit.sv
tb/sv/rf_bridge_power_vswr_meter_unit_test.sv
